>>> rtl/cpus_pkg.sv
package cpus_pkg;

	// code point width and the byte-padded stream width
	localparam int unsigned CP_W    = 21;
	localparam int unsigned TDATA_W = 24;

	localparam logic [CP_W-1:0] TILDE_CP = 21'h00007E;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_CONVERT_ENABLE      = 2'd0,
		CFG_TURKISH_DOTTED_I    = 2'd1,
		CFG_TILDE_ESCAPE_ENABLE = 2'd2
	} cfg_index_t;

	// live configuration as seen by the datapath
	typedef struct packed {
		logic convert_enable;
		logic turkish_dotted_i;
		logic tilde_escape_enable;
	} cfg_t;

endpackage

>>> rtl/codepoint_uppercase_stream_core.sv
// Channel   Direction  Handshake               Payload
// s_axis    in         tvalid / tready         tdata: code_point; tuser: first_of_text
// m_axis    out        tvalid / tready         tdata: upper_point
// cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data (bit 0)
//
// One code point per cycle while m_axis is not stalled: input register, case map, result register.
// A result moves from the input register to the result register before it is offered.
// A dropped tilde frees the input register without using the result register.
// A stall on m_axis holds the result register; the input register takes one more item,
// then s_axis_tready drops until m_axis_tready returns.
// Reset clears the configuration, the escape flag and both valid flags.
module codepoint_uppercase_stream_core
	import cpus_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// input stream
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,   // [20:0] code_point, [23:21] zero
	input  logic               s_axis_tuser,   // [0] first_of_text
	// result stream
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,   // [20:0] upper_point, [23:21] zero
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic               cfg_data
);

	cfg_t            cfg_q;
	logic            esc_q;
	logic            valid_s1;
	logic [CP_W-1:0] cp_s1;
	logic            first_s1;
	logic            valid_s2;
	logic [CP_W-1:0] point_s2;

	logic            s_fire;
	logic            s1_fire;
	logic            drop_s1;
	logic            esc_eff;
	logic            load_s2;
	logic [CP_W-1:0] mapped;
	logic [CP_W-1:0] result;

	// configuration register writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_CONVERT_ENABLE:      cfg_q.convert_enable      <= cfg_data;
				CFG_TURKISH_DOTTED_I:    cfg_q.turkish_dotted_i    <= cfg_data;
				CFG_TILDE_ESCAPE_ENABLE: cfg_q.tilde_escape_enable <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 decisions
	assign esc_eff = esc_q && !first_s1;
	assign drop_s1 = cfg_q.convert_enable && cfg_q.tilde_escape_enable && cp_s1 == TILDE_CP;
	assign s1_fire = valid_s1 && (drop_s1 || !valid_s2 || m_axis_tready);
	assign load_s2 = s1_fire && !drop_s1;
	assign s_axis_tready = !valid_s1 || s1_fire;
	assign s_fire = s_axis_tvalid && s_axis_tready;

	cpus_case_map u_map (
		.code_point       (cp_s1),
		.turkish_dotted_i (cfg_q.turkish_dotted_i),
		.upper_point      (mapped)
	);

	assign result = (!cfg_q.convert_enable || esc_eff) ? cp_s1 : mapped;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			cp_s1    <= s_axis_tdata[CP_W-1:0];
			first_s1 <= s_axis_tuser;
		end
	end

	// escape flag: set only by a dropped tilde, cleared by any other item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
		end else if (s1_fire) begin
			esc_q <= drop_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			point_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(TDATA_W-CP_W){1'b0}}, point_s2};

	// checks
	a_tilde_sets_escape: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && drop_s1 |=> esc_q)
		else $error("dropped tilde did not set escape");

	a_pass_clears_escape: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && !cfg_q.convert_enable |=> !esc_q)
		else $error("escape survived conversion off");

	a_unconverted_pass: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 && (!cfg_q.convert_enable || esc_eff) |=> point_s2 == $past(cp_s1))
		else $error("escaped or unconverted point altered");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && valid_s2)
		else $error("input stalled with room in the pipeline");

endmodule

>>> rtl/cpus_case_map.sv
module cpus_case_map
	import cpus_pkg::*;
(
	input  logic [CP_W-1:0] code_point,
	input  logic            turkish_dotted_i,
	output logic [CP_W-1:0] upper_point
);

	logic even;

	assign even = ~code_point[0];

	// first matching rule wins; anything unmatched passes unchanged
	always_comb begin
		upper_point = code_point;
		if (turkish_dotted_i && code_point == 21'h69) begin
			upper_point = 21'h130;
		end else if (code_point >= 21'h61 && code_point <= 21'h7A) begin
			upper_point = code_point - 21'h20;
		end else if (code_point >= 21'hE0 && code_point <= 21'hFE && code_point != 21'hF7) begin
			upper_point = code_point - 21'h20;
		end else if (code_point == 21'hDF) begin
			upper_point = 21'h1E9E;
		end else if (code_point == 21'hFF) begin
			upper_point = 21'h178;
		end else if (code_point == 21'h131) begin
			upper_point = 21'h49;
		end else if (code_point >= 21'h139 && code_point <= 21'h149) begin
			// L/N block: lowercase letters sit on even points here
			upper_point = even ? code_point - 21'h1 : code_point;
		end else if (code_point >= 21'h100 && code_point <= 21'h177 && !even) begin
			upper_point = code_point - 21'h1;
		end else if (code_point >= 21'h179 && code_point <= 21'h17E && even) begin
			upper_point = code_point - 21'h1;
		end else if (code_point == 21'h219 || code_point == 21'h21B) begin
			upper_point = code_point - 21'h1;
		end else if (code_point >= 21'h430 && code_point <= 21'h44F) begin
			upper_point = code_point - 21'h20;
		end else if (code_point >= 21'h450 && code_point <= 21'h45F) begin
			upper_point = code_point - 21'h50;
		end else if (code_point == 21'h491) begin
			upper_point = code_point - 21'h1;
		end else if (code_point == 21'h3C2) begin
			upper_point = 21'h3A3;
		end else if (code_point >= 21'h3B1 && code_point <= 21'h3CB) begin
			upper_point = code_point - 21'h20;
		end else if (code_point == 21'h3AC) begin
			upper_point = 21'h386;
		end else if (code_point >= 21'h3AD && code_point <= 21'h3AF) begin
			upper_point = code_point - 21'h25;
		end else if (code_point == 21'h3CC) begin
			upper_point = 21'h38C;
		end else if (code_point == 21'h3CD || code_point == 21'h3CE) begin
			upper_point = code_point - 21'h3F;
		end
	end

endmodule
